// ===== src/sm3_pkg.sv =====
// Shared types, constants and round helpers for the SM3 hash engine.
// No dependencies; every other file in src uses this package.
package sm3_pkg;

    localparam logic [31:0] T_LOW = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                   32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_digest;
    } t_out;

    typedef struct packed {
        logic [511:0] data;
        logic         fin;
    } t_blk;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

// ===== src/sm3_front.sv =====
// Front end: packs message bytes into 64-byte blocks and appends the padding.
// Depends on sm3_pkg; feeds finished blocks to sm3_queue.
module sm3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sm3_pkg::t_in  i_item,
    output logic          o_full,
    output logic          o_blk_valid,
    output sm3_pkg::t_blk o_blk,
    input  logic          i_blk_ready
);

    localparam logic [1:0] ST_ACPT = 2'd0;
    localparam logic [1:0] ST_PAD = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;
    localparam logic [7:0] PAD_BYTE_L = sm3_pkg::PAD_BYTE;

    logic [1:0]   r_state;
    logic [511:0] r_buf;
    logic [63:0]  r_bitlen;
    logic [511:0] n_buf;
    logic [511:0] blk_fill;
    logic [511:0] pad_blk;
    logic [5:0]   pos;
    logic [5:0]   off;
    logic [2:0]   cnt;
    logic [7:0]   wb;
    logic         full_blk;
    logic         accept;

    always_comb begin
        pos = r_bitlen[8:3];
        cnt = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;
        n_buf = r_buf;
        blk_fill = r_buf;
        pad_blk = r_buf;
        off = '0;
        wb = '0;
        for (int s = 0; s < 64; s++) begin
            off = 6'(s) - pos;
            wb = 8'(i_item.message_word >> {~off[1:0], 3'b000});
            if (off < {3'b000, cnt}) begin
                n_buf[511 - 8 * s -: 8] = wb;
                if (6'(s) >= pos) begin
                    blk_fill[511 - 8 * s -: 8] = wb;
                end
            end
            if (6'(s) == pos) begin
                pad_blk[511 - 8 * s -: 8] = PAD_BYTE_L;
            end else if (6'(s) > pos) begin
                pad_blk[511 - 8 * s -: 8] = 8'h00;
            end
        end
        if (pos < 6'd56) begin
            pad_blk[63:0] = r_bitlen;
        end
        full_blk = ({1'b0, pos} + {4'b0000, cnt}) >= 7'd64;
    end

    assign accept = i_push && (r_state == ST_ACPT) && i_blk_ready;
    assign o_full = !((r_state == ST_ACPT) && i_blk_ready);

    always_comb begin
        o_blk_valid = 1'b0;
        o_blk.data = blk_fill;
        o_blk.fin = 1'b0;
        unique case (r_state)
            ST_ACPT: begin
                o_blk_valid = accept && full_blk;
            end
            ST_PAD: begin
                o_blk_valid = i_blk_ready;
                o_blk.data = pad_blk;
                o_blk.fin = pos < 6'd56;
            end
            ST_LEN: begin
                o_blk_valid = i_blk_ready;
                o_blk.data = {448'b0, r_bitlen};
                o_blk.fin = 1'b1;
            end
            default: begin
                o_blk_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACPT;
            r_bitlen <= '0;
        end else begin
            unique case (r_state)
                ST_ACPT: begin
                    if (accept) begin
                        r_bitlen <= r_bitlen + {58'b0, cnt, 3'b000};
                        if (i_item.last_word) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    if (i_blk_ready) begin
                        if (pos < 6'd56) begin
                            r_bitlen <= '0;
                            r_state <= ST_ACPT;
                        end else begin
                            r_state <= ST_LEN;
                        end
                    end
                end
                ST_LEN: begin
                    if (i_blk_ready) begin
                        r_bitlen <= '0;
                        r_state <= ST_ACPT;
                    end
                end
                default: begin
                    r_state <= ST_ACPT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end
    end

endmodule

// ===== src/sm3_queue.sv =====
// Two-entry block queue between the packing front end and the compression core.
// Depends on sm3_pkg for the block type.
module sm3_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  sm3_pkg::t_blk i_wr_data,
    output logic          o_wr_ready,
    output logic          o_rd_valid,
    output sm3_pkg::t_blk o_rd_data,
    input  logic          i_rd_pop
);

    sm3_pkg::t_blk r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_wr_ready = r_cnt != 2'd2;
    assign o_rd_valid = r_cnt != 2'd0;
    assign o_rd_data = r_mem[r_rp];
    assign wr_en = i_wr_valid && o_wr_ready;
    assign rd_en = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

// ===== src/sm3_core.sv =====
// Compression core: message expansion and 64 SM3 rounds, one round per cycle.
// Depends on sm3_pkg; takes blocks from sm3_queue and hands out finished digests.
module sm3_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_blk_valid,
    input  sm3_pkg::t_blk i_blk,
    output logic          o_blk_pop,
    output logic          o_dig_valid,
    output logic [255:0]  o_dig,
    input  logic          i_dig_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0]  r_state;
    logic [5:0]  r_j;
    logic        r_fin;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_cv [8];

    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, nw;

    always_comb begin
        a12 = sm3_pkg::rotl32(r_v[0], 5'd12);
        tj = (r_j < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
        ss1 = sm3_pkg::rotl32(a12 + r_v[4] + sm3_pkg::rotl32(tj, r_j[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_j < 6'd16) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_v[7] + ss1 + r_w[0];
        nw = sm3_pkg::perm1(r_w[0] ^ r_w[7] ^ sm3_pkg::rotl32(r_w[13], 5'd15))
             ^ sm3_pkg::rotl32(r_w[3], 5'd7) ^ r_w[10];
    end

    assign o_blk_pop = (r_state == ST_IDLE) && i_blk_valid;
    assign o_dig_valid = (r_state == ST_FOLD) && r_fin;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_dig[255 - 32 * i -: 32] = r_cv[i] ^ r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j <= '0;
            r_fin <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= sm3_pkg::IV[255 - 32 * i -: 32];
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_blk_valid) begin
                        r_j <= '0;
                        r_fin <= i_blk.fin;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_j <= r_j + 6'd1;
                    if (r_j == 6'd63) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (!r_fin) begin
                        for (int i = 0; i < 8; i++) begin
                            r_cv[i] <= r_cv[i] ^ r_v[i];
                        end
                        r_state <= ST_IDLE;
                    end else if (i_dig_ready) begin
                        for (int i = 0; i < 8; i++) begin
                            r_cv[i] <= sm3_pkg::IV[255 - 32 * i -: 32];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_blk_valid) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_blk.data[511 - 32 * i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_cv[i];
            end
        end else if (r_state == ST_RUN) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= nw;
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= sm3_pkg::rotl32(r_v[1], 5'd9);
            r_v[3] <= r_v[2];
            r_v[4] <= sm3_pkg::perm0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= sm3_pkg::rotl32(r_v[5], 5'd19);
            r_v[7] <= r_v[6];
        end
    end

endmodule

// ===== src/sm3_hash_engine.sv =====
// Top level of the SM3 hash engine: front end, block queue, core and digest output.
// Depends on sm3_pkg, sm3_front, sm3_queue and sm3_core.
//
// Channel   Direction  Handshake            Transaction
// item      in         push / full          one message word with byte count and end flag
// result    out        pop / empty          one digest word with its index and end flag
//
// Each 64-byte block goes through the core as load, 64 rounds, then fold.
// Full words arrive at up to one per cycle, except while padding or with the two-entry block queue full.
// A final word adds one or two padding blocks before the eight digest words appear.
// Reset is synchronous and returns the chaining value to the IV.
// A digest not yet popped stalls the core at its next final block.
module sm3_hash_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  sm3_pkg::t_in  i_item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output sm3_pkg::t_out o_result
);

    logic          f_valid;
    sm3_pkg::t_blk f_blk;
    logic          f_ready;
    logic          q_valid;
    sm3_pkg::t_blk q_blk;
    logic          q_pop;
    logic          d_valid;
    logic [255:0]  d_data;
    logic [255:0]  r_dig;
    logic          r_dv;
    logic [2:0]    r_idx;

    sm3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_blk_valid (f_valid),
        .o_blk       (f_blk),
        .i_blk_ready (f_ready)
    );

    sm3_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .i_wr_data  (f_blk),
        .o_wr_ready (f_ready),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_blk),
        .i_rd_pop   (q_pop)
    );

    sm3_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk_valid (q_valid),
        .i_blk       (q_blk),
        .o_blk_pop   (q_pop),
        .o_dig_valid (d_valid),
        .o_dig       (d_data),
        .i_dig_ready (!r_dv)
    );

    assign empty = !r_dv;
    assign o_result.digest_word = r_dig[255 - 32 * r_idx -: 32];
    assign o_result.digest_index = r_idx;
    assign o_result.last_digest = r_idx == 3'd7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_idx <= '0;
        end else if (!r_dv) begin
            if (d_valid) begin
                r_dv <= 1'b1;
                r_idx <= '0;
            end
        end else if (pop) begin
            r_idx <= r_idx + 3'd1;
            if (r_idx == 3'd7) begin
                r_dv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_dv && d_valid) begin
            r_dig <= d_data;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_result.last_digest) |=> empty)
        else $error("digest still shown after its last word");
    a_mid_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last_digest) |=> (!empty && o_result.digest_index != 3'd0))
        else $error("digest cut short");

endmodule

// ===== tb/sv/sm3_digest_checker.sv =====
// Watches the item and result channels of the SM3 hash engine, predicts digests and compares.
// Depends on sm3_pkg for the transaction types and the SM3 constants.
`timescale 1ns / 100ps
module sm3_digest_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  sm3_pkg::t_in  i_item,
    input  logic          full,
    input  logic          empty,
    input  logic          pop,
    input  sm3_pkg::t_out o_result,
    output int            o_errors,
    output int            o_pending,
    output int            o_digests
);
    import sm3_pkg::*;

    logic [31:0] chain_val [8];
    logic [31:0] blk_words [16];
    logic [63:0] msg_bits;
    t_out        digest_q [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        logic [63:0] tmp;
        tmp = {x, x} << (n % 32);
        return tmp[63:32];
    endfunction

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] r [8];
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
        for (int i = 0; i < 16; i++) w[i] = blk_words[i];
        for (int i = 0; i < 8; i++) r[i] = chain_val[i];
        for (int j = 0; j < 64; j++) begin
            tj = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol(r[0], 12);
            ss1 = rol(a12 + r[4] + rol(tj, j % 32), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end else begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (w[0] ^ w[4]);
            tt2 = gg + r[7] + ss1 + w[0];
            r[3] = r[2];
            r[2] = rol(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rol(r[5], 19);
            r[5] = r[4];
            r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
            nw = w[0] ^ w[7] ^ rol(w[13], 15);
            nw = (nw ^ rol(nw, 15) ^ rol(nw, 23)) ^ rol(w[3], 7) ^ w[10];
            for (int k = 0; k < 15; k++) w[k] = w[k + 1];
            w[15] = nw;
        end
        for (int i = 0; i < 8; i++) chain_val[i] ^= r[i];
    endtask

    task automatic put_byte(input int pos, input logic [7:0] b);
        blk_words[pos / 4][31 - 8 * (pos % 4) -: 8] = b;
        if (pos == 63) compress();
    endtask

    task automatic restart();
        for (int i = 0; i < 8; i++) chain_val[i] = IV[255 - 32 * i -: 32];
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
        msg_bits = '0;
    endtask

    task automatic absorb(input t_in it);
        int cnt;
        int pos;
        logic [63:0] len;
        t_out d;
        cnt = (it.byte_count > 4) ? 4 : it.byte_count;
        for (int i = 0; i < cnt; i++) begin
            put_byte(msg_bits[8:3], it.message_word[31 - 8 * i -: 8]);
            msg_bits += 8;
        end
        if (it.last_word) begin
            len = msg_bits;
            pos = len[8:3];
            put_byte(pos, PAD_BYTE);
            pos = (pos + 1) % 64;
            while (pos != 56) begin
                put_byte(pos, 8'h00);
                pos = (pos + 1) % 64;
            end
            for (int i = 0; i < 8; i++) begin
                put_byte(pos, len[63 - 8 * i -: 8]);
                pos = (pos + 1) % 64;
            end
            for (int i = 0; i < 8; i++) begin
                d.digest_word = chain_val[i];
                d.digest_index = 3'(i);
                d.last_digest = (i == 7);
                digest_q = {digest_q, d};
            end
            restart();
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_d;
        if (!i_rst_n) begin
            restart();
            digest_q.delete();
            o_errors = 0;
            o_digests = 0;
        end else begin
            if (push && !full) absorb(i_item);
            if (pop && !empty) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_result);
                    o_errors++;
                end else begin
                    exp_d = digest_q.pop_front();
                    if (exp_d !== o_result) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_d, o_result);
                        o_errors++;
                    end
                    if (exp_d.last_digest) o_digests++;
                end
            end
        end
        o_pending = digest_q.size();
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the SM3 hash engine testbench: clock, reset, message stimulus and verdict.
// Depends on sm3_pkg, sm3_hash_engine and sm3_digest_checker.
`timescale 1ns / 100ps
module tb_top;
    import sm3_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_in  i_item = '0;
    logic full, empty;
    t_out o_result;
    int   n_err, n_pend, n_dig;
    int   n_items = 0;

    sm3_hash_engine uut (.*);

    sm3_digest_checker chk (
        .i_clk, .i_rst_n, .push, .i_item, .full, .empty, .pop, .o_result,
        .o_errors(n_err), .o_pending(n_pend), .o_digests(n_dig)
    );

    always #10 i_clk = ~i_clk;

    task automatic send(input logic [31:0] w, input logic [2:0] c, input logic l);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{message_word: w, byte_count: c, last_word: l};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_items++;
    endtask

    task automatic send_msg(input int nbytes);
        int left;
        int c;
        left = nbytes;
        while (left > 4) begin
            c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 4;
            if (c > left) c = left;
            send($urandom, 3'(c), 1'b0);
            left -= (c > 4) ? 4 : c;
        end
        send($urandom, 3'(left), 1'b1);
    endtask

    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                if (!empty) stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(32'h0, 3'd0, 1'b1);
        send(32'h61626300, 3'd3, 1'b1);
        for (int i = 0; i < 16; i++) send(32'h61626364, 3'd4, i == 15);
        send(32'hFFFFFFFF, 3'd7, 1'b0);
        send(32'h12345678, 3'd1, 1'b0);
        send(32'hFFFFFFFF, 3'd5, 1'b0);
        send(32'hABCDEF01, 3'd2, 1'b0);
        send(32'hFFFFFFFF, 3'd6, 1'b1);
        push <= 1'b0;
        @(posedge i_clk);
        while (n_pend != 0) @(posedge i_clk);
        for (int l = 52; l <= 60; l += 4) send_msg(l);
        while (n_items < 110) send_msg($urandom_range(0, 130));
        push <= 1'b0;
        @(posedge i_clk);
        while (n_pend != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d words in messages of 0 to 130 bytes, short and oversized counts.",
                 n_items);
        $display("Checked %0d digests, padding across block boundaries included.", n_dig);
        if (n_err == 0 && n_pend == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
